// ===== rtl/ttle_pkg.sv =====
// Shared types and constants of the tracking table core.
// No dependencies.
`timescale 1ns / 1ps
package ttle_pkg;

  localparam int ENTRIES        = 64;
  localparam int IDX_W          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W          = $clog2(ENTRIES + 1);
  localparam logic [31:0] EXPIRY_RESET = 32'd300000;
  localparam logic [31:0] MSG_MAX      = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_UPSERT = 2'd0,
    OP_SWEEP  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_EVICTED  = 3'd2,
    ST_SWEPT    = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0]         dec;
    logic [31:0]        key;
    logic [31:0]        first;
    logic [31:0]        last;
    logic [31:0]        msgs;
    logic signed [7:0]  rssi;
  } entry_t;

  typedef struct packed {
    op_e                op;
    logic [7:0]         dec;
    logic [31:0]        key;
    logic signed [7:0]  rssi;
    logic [31:0]        now;
    logic               sweep_en;
    logic               match_all;
    logic [31:0]        cutoff;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    status_e            status;
    entry_t             ent;
    logic [CNT_W-1:0]   removed;
    logic [CNT_W-1:0]   occ;
    logic               last;
  } result_t;

endpackage

// ===== rtl/tracking_table_lru_expiry_core.sv =====
// Tracking table with oldest-entry eviction and age-based expiry sweep.
// Usage: a command is transferred when start is high and busy is low; the
// fields opcode, decoder id, object key, signal strength and time go with it.
// Commands enter a two-deep queue; busy is high while that queue is full.
// Each result is shown for one cycle with result_strobe_o; last_of_run_o
// marks the final result of a command. The receiver cannot stall.
// With n the occupancy, an upsert scans the slots and updates a matching one;
// if none matches it inserts at slot n or, when the table is full, evicts the
// least recently seen entry by first moving the last slot into its place. Query
// and dump stream one report per matching slot, or one empty report if none do.
// A sweep checks each slot and fills a removed slot with a copy of the last one
// (none when the removed slot is the last one); a disabled sweep does no scan.
// Commands run one at a time; a queued one starts as its predecessor's
// result is shown.
// The expiry register is written with expiry_time_ms_we_i; the user must do so
// only while the core is idle, which the core does not enforce. Reset empties
// the table and loads the expiry of 300000 ms; no clearing pass is needed.
// Depends on ttle_pkg, ttle_front, ttle_back.
`timescale 1ns / 1ps
module tracking_table_lru_expiry_core import ttle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         decoder_id_i,
  input  logic [31:0]        object_key_i,
  input  logic signed [7:0]  signal_strength_i,
  input  logic [31:0]        now_ms_i,
  input  logic               expiry_time_ms_we_i,
  input  logic [31:0]        expiry_time_ms_i,
  output logic               result_strobe_o,
  output logic [2:0]         status_o,
  output logic [7:0]         entry_decoder_o,
  output logic [31:0]        entry_key_o,
  output logic [31:0]        first_seen_o,
  output logic [31:0]        last_seen_o,
  output logic [31:0]        message_total_o,
  output logic signed [7:0]  entry_rssi_o,
  output logic [6:0]         removed_count_o,
  output logic [6:0]         occupancy_o,
  output logic               last_of_run_o
);

  logic    cmd_valid, cmd_pop;
  cmd_t    cmd;
  result_t res;

  ttle_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .opcode_i            (opcode_i),
    .decoder_id_i        (decoder_id_i),
    .object_key_i        (object_key_i),
    .signal_strength_i   (signal_strength_i),
    .now_ms_i            (now_ms_i),
    .expiry_time_ms_we_i (expiry_time_ms_we_i),
    .expiry_time_ms_i    (expiry_time_ms_i),
    .cmd_valid_o         (cmd_valid),
    .cmd_o               (cmd),
    .cmd_pop_i           (cmd_pop)
  );

  ttle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res)
  );

  assign result_strobe_o = res.valid;
  assign status_o        = res.status;
  assign entry_decoder_o = res.ent.dec;
  assign entry_key_o     = res.ent.key;
  assign first_seen_o    = res.ent.first;
  assign last_seen_o     = res.ent.last;
  assign message_total_o = res.ent.msgs;
  assign entry_rssi_o    = res.ent.rssi;
  assign removed_count_o = 7'(res.removed);
  assign occupancy_o     = 7'(res.occ);
  assign last_of_run_o   = res.last;

endmodule

// ===== rtl/ttle_front.sv =====
// Front end: expiry register, command classification and a two-deep command queue.
// Depends on ttle_pkg.
`timescale 1ns / 1ps
module ttle_front import ttle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         decoder_id_i,
  input  logic [31:0]        object_key_i,
  input  logic signed [7:0]  signal_strength_i,
  input  logic [31:0]        now_ms_i,
  input  logic               expiry_time_ms_we_i,
  input  logic [31:0]        expiry_time_ms_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_pop_i
);

  logic [31:0] expiry_q;
  cmd_t        fifo_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  cmd_t        cmd_in;
  logic        push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= EXPIRY_RESET;
    end else if (expiry_time_ms_we_i) begin
      expiry_q <= expiry_time_ms_i;
    end
  end

  always_comb begin
    cmd_in.op        = op_e'(opcode_i);
    cmd_in.dec       = decoder_id_i;
    cmd_in.key       = object_key_i;
    cmd_in.rssi      = signal_strength_i;
    cmd_in.now       = now_ms_i;
    cmd_in.sweep_en  = (expiry_q != 32'd0) && (now_ms_i >= expiry_q);
    cmd_in.match_all = (op_e'(opcode_i) == OP_DUMP);
    cmd_in.cutoff    = now_ms_i - expiry_q;
  end

  assign busy        = (cnt_q == 2'd2);
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (cmd_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule

// ===== rtl/ttle_back.sv =====
// Back end: table memory and the sequencer for upsert, sweep, query and dump.
// Depends on ttle_pkg.
`timescale 1ns / 1ps
module ttle_back import ttle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  cmd_t     cmd_i,
  output logic     cmd_pop_o,
  output result_t  res_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN   = 9'b000000010,
    S_EVRD   = 9'b000000100,
    S_EVWR   = 9'b000001000,
    S_INS    = 9'b000010000,
    S_SWRD   = 9'b000100000,
    S_SWCHK  = 9'b001000000,
    S_SWRDL  = 9'b010000000,
    S_SWCOPY = 9'b100000000
  } state_e;

  entry_t mem [ENTRIES];
  entry_t rdata_q;
  logic [IDX_W-1:0] raddr, waddr;
  logic             we;
  entry_t           wdata;

  state_e           state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [CNT_W-1:0] used_q, used_d, rd_i_q, rd_i_d, rem_q, rem_d;
  logic             chk_v_q, chk_v_d, pend_v_q, pend_v_d;
  logic [IDX_W-1:0] chk_i_q, chk_i_d, old_q, old_d, ins_q, ins_d;
  logic [31:0]      min_q, min_d;
  entry_t           pend_q, pend_d;
  status_e          ist_q, ist_d;
  result_t          res_q, res_d;
  logic [CNT_W-1:0] last_idx;
  logic             issue, hit;
  entry_t           upd, fresh;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign last_idx = used_q - CNT_W'(1);
  assign issue    = (rd_i_q < used_q);
  assign hit      = chk_v_q && (cmd_q.match_all || rdata_q.dec == cmd_q.dec);

  always_comb begin
    upd       = rdata_q;
    upd.last  = cmd_q.now;
    upd.msgs  = (rdata_q.msgs == MSG_MAX) ? MSG_MAX : rdata_q.msgs + 32'd1;
    upd.rssi  = cmd_q.rssi;
    fresh.dec   = cmd_q.dec;
    fresh.key   = cmd_q.key;
    fresh.first = cmd_q.now;
    fresh.last  = cmd_q.now;
    fresh.msgs  = 32'd1;
    fresh.rssi  = cmd_q.rssi;
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    used_d   = used_q;
    rd_i_d   = rd_i_q;
    rem_d    = rem_q;
    chk_v_d  = 1'b0;
    chk_i_d  = chk_i_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    old_d    = old_q;
    min_d    = min_q;
    ins_d    = ins_q;
    ist_d    = ist_q;
    raddr    = rd_i_q[IDX_W-1:0];
    we       = 1'b0;
    waddr    = chk_i_q;
    wdata    = upd;
    cmd_pop_o = 1'b0;
    res_d        = '0;
    res_d.status = ST_SWEPT;
    res_d.occ    = used_q;
    res_d.last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          rd_i_d    = '0;
          rem_d     = '0;
          pend_v_d  = 1'b0;
          if (cmd_i.op == OP_SWEEP) begin
            if (cmd_i.sweep_en) begin
              state_d = S_SWRD;
            end else begin
              res_d.valid = 1'b1;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        chk_v_d = issue;
        chk_i_d = rd_i_q[IDX_W-1:0];
        if (issue) begin
          rd_i_d = rd_i_q + CNT_W'(1);
        end
        if (cmd_q.op == OP_UPSERT) begin
          if (chk_v_q && rdata_q.key == cmd_q.key && rdata_q.dec == cmd_q.dec) begin
            we          = 1'b1;
            res_d.valid = 1'b1;
            res_d.status = ST_UPDATED;
            res_d.ent   = upd;
            state_d     = S_IDLE;
          end else begin
            if (chk_v_q && (chk_i_q == '0 || rdata_q.last < min_q)) begin
              old_d = chk_i_q;
              min_d = rdata_q.last;
            end
            if (!issue && !chk_v_q) begin
              if (used_q < CNT_W'(ENTRIES)) begin
                ins_d   = used_q[IDX_W-1:0];
                ist_d   = ST_INSERTED;
                state_d = S_INS;
              end else begin
                ins_d   = last_idx[IDX_W-1:0];
                ist_d   = ST_EVICTED;
                state_d = (old_q == last_idx[IDX_W-1:0]) ? S_INS : S_EVRD;
              end
            end
          end
        end else begin
          if (hit) begin
            pend_d   = rdata_q;
            pend_v_d = 1'b1;
            if (pend_v_q) begin
              res_d.valid  = 1'b1;
              res_d.status = ST_ENTRY;
              res_d.ent    = pend_q;
              res_d.last   = 1'b0;
            end
          end
          if (!issue && !chk_v_q) begin
            res_d.valid  = 1'b1;
            res_d.status = pend_v_q ? ST_ENTRY : ST_EMPTY;
            res_d.ent    = pend_v_q ? pend_q : '0;
            state_d      = S_IDLE;
          end
        end
      end
      S_EVRD: begin
        raddr   = last_idx[IDX_W-1:0];
        state_d = S_EVWR;
      end
      S_EVWR: begin
        we      = 1'b1;
        waddr   = old_q;
        wdata   = rdata_q;
        state_d = S_INS;
      end
      S_INS: begin
        we           = 1'b1;
        waddr        = ins_q;
        wdata        = fresh;
        used_d       = CNT_W'(ins_q) + CNT_W'(1);
        res_d.valid  = 1'b1;
        res_d.status = ist_q;
        res_d.ent    = fresh;
        res_d.occ    = used_d;
        state_d      = S_IDLE;
      end
      S_SWRD: begin
        if (rd_i_q < used_q) begin
          state_d = S_SWCHK;
        end else begin
          res_d.valid   = 1'b1;
          res_d.removed = rem_q;
          state_d       = S_IDLE;
        end
      end
      S_SWCHK: begin
        if (rdata_q.last < cmd_q.cutoff) begin
          rem_d = rem_q + CNT_W'(1);
          if (rd_i_q == last_idx) begin
            used_d  = last_idx;
            state_d = S_SWRD;
          end else begin
            state_d = S_SWRDL;
          end
        end else begin
          rd_i_d  = rd_i_q + CNT_W'(1);
          state_d = S_SWRD;
        end
      end
      S_SWRDL: begin
        raddr   = last_idx[IDX_W-1:0];
        state_d = S_SWCOPY;
      end
      S_SWCOPY: begin
        we      = 1'b1;
        waddr   = rd_i_q[IDX_W-1:0];
        wdata   = rdata_q;
        used_d  = last_idx;
        state_d = S_SWRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      chk_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      chk_v_q  <= chk_v_d;
      pend_v_q <= pend_v_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    rd_i_q  <= rd_i_d;
    rem_q   <= rem_d;
    chk_i_q <= chk_i_d;
    pend_q  <= pend_d;
    old_q   <= old_d;
    min_q   <= min_d;
    ins_q   <= ins_d;
    ist_q   <= ist_d;
  end

  assign res_o = res_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(ENTRIES))
    else $error("occupancy above table size");

  a_nonlast_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.valid && !res_q.last |-> res_q.status == ST_ENTRY)
    else $error("non-final result that is not an entry report");

  a_upsert_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.valid && (res_q.status == ST_UPDATED || res_q.status == ST_INSERTED ||
                    res_q.status == ST_EVICTED) |-> res_q.occ != '0)
    else $error("upsert left an empty table");

  a_sweep_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWCOPY |=> used_q == $past(used_q) - CNT_W'(1))
    else $error("sweep copy did not shrink the table");

endmodule
